// File: hw/rtl/ps2s1_pkg.sv
// ----------------------------------------------------------------------------
// ps2s1_pkg
// Shared types, key codes and character tables for the set 1 translator.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2s1_pkg;

  // scancode bytes and key codes
  localparam logic [7:0] EXT_PREFIX = 8'hE0;
  localparam int unsigned BREAK_BIT = 7;
  localparam logic [6:0] KEY_LSHIFT   = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT   = 7'h36;
  localparam logic [6:0] KEY_CTRL     = 7'h1D;
  localparam logic [6:0] KEY_ALT      = 7'h38;
  localparam logic [6:0] KEY_CAPS     = 7'h3A;
  localparam logic [6:0] KEY_KP_ENTER = 7'h1C;
  localparam logic [6:0] KEY_KP_SLASH = 7'h35;
  localparam logic [6:0] TABLE_SIZE   = 7'h3A;

  // characters used outside the tables
  localparam logic [6:0] CH_LF    = 7'h0A;
  localparam logic [6:0] CH_SLASH = 7'h2F;
  localparam logic [6:0] CASE_BIT = 7'h20;

  // queue depths
  localparam int unsigned JOB_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 2;

  localparam int unsigned KEY_W   = 6;
  localparam int unsigned ASCII_W = 7;

  // one translation job handed from the front to the back
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             ext;
    logic             shift;
    logic             ctrl;
    logic             caps;
  } job_t;

  localparam int unsigned JOB_W = $bits(job_t);

  // unshifted table
  function automatic logic [6:0] rom_plain(input logic [KEY_W-1:0] key);
    logic [6:0] ch;
    unique case (key)
      6'h01: ch = 7'h1B;
      6'h02: ch = 7'h31;
      6'h03: ch = 7'h32;
      6'h04: ch = 7'h33;
      6'h05: ch = 7'h34;
      6'h06: ch = 7'h35;
      6'h07: ch = 7'h36;
      6'h08: ch = 7'h37;
      6'h09: ch = 7'h38;
      6'h0A: ch = 7'h39;
      6'h0B: ch = 7'h30;
      6'h0C: ch = 7'h2D;
      6'h0D: ch = 7'h3D;
      6'h0E: ch = 7'h08;
      6'h0F: ch = 7'h09;
      6'h10: ch = 7'h71;
      6'h11: ch = 7'h77;
      6'h12: ch = 7'h65;
      6'h13: ch = 7'h72;
      6'h14: ch = 7'h74;
      6'h15: ch = 7'h79;
      6'h16: ch = 7'h75;
      6'h17: ch = 7'h69;
      6'h18: ch = 7'h6F;
      6'h19: ch = 7'h70;
      6'h1A: ch = 7'h5B;
      6'h1B: ch = 7'h5D;
      6'h1C: ch = 7'h0A;
      6'h1E: ch = 7'h61;
      6'h1F: ch = 7'h73;
      6'h20: ch = 7'h64;
      6'h21: ch = 7'h66;
      6'h22: ch = 7'h67;
      6'h23: ch = 7'h68;
      6'h24: ch = 7'h6A;
      6'h25: ch = 7'h6B;
      6'h26: ch = 7'h6C;
      6'h27: ch = 7'h3B;
      6'h28: ch = 7'h27;
      6'h29: ch = 7'h60;
      6'h2B: ch = 7'h5C;
      6'h2C: ch = 7'h7A;
      6'h2D: ch = 7'h78;
      6'h2E: ch = 7'h63;
      6'h2F: ch = 7'h76;
      6'h30: ch = 7'h62;
      6'h31: ch = 7'h6E;
      6'h32: ch = 7'h6D;
      6'h33: ch = 7'h2C;
      6'h34: ch = 7'h2E;
      6'h35: ch = 7'h2F;
      6'h37: ch = 7'h2A;
      6'h39: ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  // true for a to z and A to Z
  function automatic logic is_letter(input logic [6:0] ch);
    return ((ch >= 7'h61) && (ch <= 7'h7A)) || ((ch >= 7'h41) && (ch <= 7'h5A));
  endfunction

  // shifted table: symbols listed, letters go upper case, rest as plain
  function automatic logic [6:0] rom_shift(input logic [KEY_W-1:0] key);
    logic [6:0] ch;
    logic [6:0] base;
    base = rom_plain(key);
    unique case (key)
      6'h02: ch = 7'h21;
      6'h03: ch = 7'h40;
      6'h04: ch = 7'h23;
      6'h05: ch = 7'h24;
      6'h06: ch = 7'h25;
      6'h07: ch = 7'h5E;
      6'h08: ch = 7'h26;
      6'h09: ch = 7'h2A;
      6'h0A: ch = 7'h28;
      6'h0B: ch = 7'h29;
      6'h0C: ch = 7'h5F;
      6'h0D: ch = 7'h2B;
      6'h1A: ch = 7'h7B;
      6'h1B: ch = 7'h7D;
      6'h27: ch = 7'h3A;
      6'h28: ch = 7'h22;
      6'h29: ch = 7'h7E;
      6'h2B: ch = 7'h7C;
      6'h33: ch = 7'h3C;
      6'h34: ch = 7'h3E;
      6'h35: ch = 7'h3F;
      default: ch = is_letter(base) ? (base ^ CASE_BIT) : base;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ps2s1_queue.sv
// ----------------------------------------------------------------------------
// ps2s1_queue
// Small synchronous first-in first-out queue with push/full and pop/empty.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2s1_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ps2s1_front.sv
// ----------------------------------------------------------------------------
// ps2s1_front
// Tracks prefix and modifier state per scancode byte and issues jobs for
// make codes that can yield a character.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2s1_front (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] scan_byte,
  output logic            job_valid,
  output ps2s1_pkg::job_t job
);

  logic extended_pending;
  logic left_shift_down;
  logic right_shift_down;
  logic control_down;
  logic caps_lock_on;

  logic       is_prefix;
  logic       brk;
  logic [6:0] key;
  logic       is_modifier;
  logic       ext_ok;

  // byte decode
  assign is_prefix = (scan_byte == ps2s1_pkg::EXT_PREFIX);
  assign brk       = scan_byte[ps2s1_pkg::BREAK_BIT];
  assign key       = scan_byte[6:0];

  assign is_modifier = (key == ps2s1_pkg::KEY_LSHIFT) || (key == ps2s1_pkg::KEY_RSHIFT) ||
                       (key == ps2s1_pkg::KEY_CTRL)   || (key == ps2s1_pkg::KEY_ALT)    ||
                       (key == ps2s1_pkg::KEY_CAPS);
  assign ext_ok = (key == ps2s1_pkg::KEY_KP_ENTER) || (key == ps2s1_pkg::KEY_KP_SLASH);

  // a job only for make codes that may produce a character
  assign job_valid = !is_prefix && !brk && !is_modifier &&
                     (extended_pending ? ext_ok : (key < ps2s1_pkg::TABLE_SIZE));

  assign job.key   = key[ps2s1_pkg::KEY_W-1:0];
  assign job.ext   = extended_pending;
  assign job.shift = left_shift_down || right_shift_down;
  assign job.ctrl  = control_down;
  assign job.caps  = caps_lock_on;

  // prefix and modifier flags
  always_ff @(posedge clk) begin
    if (rst) begin
      extended_pending <= 1'b0;
      left_shift_down  <= 1'b0;
      right_shift_down <= 1'b0;
      control_down     <= 1'b0;
      caps_lock_on     <= 1'b0;
    end else if (accept) begin
      extended_pending <= is_prefix;
      if (!is_prefix) begin
        if ((key == ps2s1_pkg::KEY_LSHIFT) && !extended_pending) begin
          left_shift_down <= !brk;
        end
        if ((key == ps2s1_pkg::KEY_RSHIFT) && !extended_pending) begin
          right_shift_down <= !brk;
        end
        if (key == ps2s1_pkg::KEY_CTRL) begin
          control_down <= !brk;
        end
        if ((key == ps2s1_pkg::KEY_CAPS) && !brk) begin
          caps_lock_on <= !caps_lock_on;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ps2s1_back.sv
// ----------------------------------------------------------------------------
// ps2s1_back
// Turns one job into a character through the key tables and the ctrl and
// caps rules, dropping jobs that give no character.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2s1_back (
  input  wire logic                job_empty,
  input  wire ps2s1_pkg::job_t     job,
  output logic                     job_pop,
  input  wire logic                out_full,
  output logic                     out_push,
  output logic [6:0]               out_data
);

  logic [6:0] base;
  logic [6:0] ch;

  // table lookup
  assign base = job.shift ? ps2s1_pkg::rom_shift(job.key) : ps2s1_pkg::rom_plain(job.key);

  // keypad keys, then ctrl letters, then caps inversion
  always_comb begin
    if (job.ext) begin
      ch = (job.key == ps2s1_pkg::KEY_KP_ENTER[ps2s1_pkg::KEY_W-1:0]) ?
           ps2s1_pkg::CH_LF : ps2s1_pkg::CH_SLASH;
    end else if (job.ctrl) begin
      ch = ps2s1_pkg::is_letter(base) ? {2'b00, base[4:0]} : 7'h00;
    end else if (job.caps && ps2s1_pkg::is_letter(base)) begin
      ch = base ^ ps2s1_pkg::CASE_BIT;
    end else begin
      ch = base;
    end
  end

  // one job a cycle while the result queue has room
  assign job_pop  = !job_empty && !out_full;
  assign out_push = job_pop && (ch != 7'h00);
  assign out_data = ch;

endmodule

`default_nettype wire

// File: hw/rtl/ps2_set1_scancode_to_ascii_core.sv
// ----------------------------------------------------------------------------
// ps2_set1_scancode_to_ascii_core
// Scancode set 1 byte stream to US-layout ASCII characters.
//
// Input side is a queue write port: a byte on scan_byte is taken at a clock
// edge with push high and full low. Output side is a queue read port: while
// empty is low the oldest character is on ascii_code, and pop takes it.
// Prefix, shift, ctrl and caps bytes update internal flags and give no
// character; break codes and unmapped keys give none either.
// Throughput is one byte per cycle while full is low. A byte that yields a
// character is written into the job queue when taken; from its head the
// table lookup moves it to the result queue and the output once that has room.
// Each queue holds two words; when pop stays low the result queue fills,
// the back end stops taking jobs, the job queue fills and full rises.
// Synchronous reset clears all key flags and empties both queues; the
// block takes bytes in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_set1_scancode_to_ascii_core #(
  parameter int unsigned JOB_DEPTH = ps2s1_pkg::JOB_DEPTH,
  parameter int unsigned OUT_DEPTH = ps2s1_pkg::OUT_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] scan_byte,
  input  wire logic       pop,
  output logic            empty,
  output logic [6:0]      ascii_code
);

  logic            accept;
  logic            job_valid;
  ps2s1_pkg::job_t job_in;
  ps2s1_pkg::job_t job_head;
  logic            job_empty;
  logic            job_pop;
  logic            out_full;
  logic            out_push;
  logic [6:0]      out_data;

  assign accept = push && !full;

  // flag tracking and classification
  ps2s1_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .scan_byte (scan_byte),
    .job_valid (job_valid),
    .job       (job_in)
  );

  // jobs between front and back
  ps2s1_queue #(
    .WIDTH (ps2s1_pkg::JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_job_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept && job_valid),
    .wdata (job_in),
    .full  (full),
    .pop   (job_pop),
    .rdata (job_head),
    .empty (job_empty)
  );

  // character lookup
  ps2s1_back u_back (
    .job_empty (job_empty),
    .job       (job_head),
    .job_pop   (job_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_data  (out_data)
  );

  // result words
  ps2s1_queue #(
    .WIDTH (ps2s1_pkg::ASCII_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_data),
    .full  (out_full),
    .pop   (pop),
    .rdata (ascii_code),
    .empty (empty)
  );

endmodule

`default_nettype wire

// File: hw/rtl/ps2s1_checker.sv
// ----------------------------------------------------------------------------
// ps2s1_checker
// Port-level checks for the scancode translator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2s1_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       push,
  input wire logic       full,
  input wire logic       pop,
  input wire logic       empty,
  input wire logic [6:0] ascii_code
);

  // reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not idle after reset");

  // a character word is never zero
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (ascii_code != 7'h00))
    else $error("zero character word offered");

  // with the output drained and no new byte, the input side frees up
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (empty && !push) |=> !full)
    else $error("full held with output drained");

  // a waiting word holds while not taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(ascii_code)))
    else $error("waiting word changed or dropped");

endmodule

bind ps2_set1_scancode_to_ascii_core ps2s1_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .push       (push),
  .full       (full),
  .pop        (pop),
  .empty      (empty),
  .ascii_code (ascii_code)
);

`default_nettype wire

// File: verif/ps2_set1_scancode_to_ascii_core_tb.sv
// ----------------------------------------------------------------------------
// ps2_set1_scancode_to_ascii_core_tb
// Self-checking bench for the set 1 scancode to ASCII translator. A short
// table of hand-picked bytes (table extremes, break and prefix handling,
// fake shift, ctrl letters, caps, keypad enter and slash) is followed by
// random typing: key presses and releases, modifiers, prefixed sequences
// and noise bytes. Each character is predicted by a local model of the key
// flags and compared in order; push and pop idle at random per phase.
// ----------------------------------------------------------------------------
module ps2_set1_scancode_to_ascii_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WORDS_PER_PHASE = 463;
  localparam int unsigned DRAIN_CYCLES = 20;

  // how a directed row gets its expectation
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_CHAR
  } row_kind_t;

  typedef struct packed {
    logic [7:0] scan;
    row_kind_t  kind;
    logic [6:0] want;
  } row_t;

  localparam int unsigned NUM_ROWS = 30;

  // directed stimulus, walked in order right after reset
  row_t directed_rows [NUM_ROWS] = '{
    '{8'h00, ROW_SILENT,  7'h00},  // empty table entry
    '{8'h80, ROW_SILENT,  7'h00},  // break of code zero
    '{8'h01, ROW_CHAR,    7'h1B},  // escape
    '{8'h1E, ROW_CHAR,    7'h61},  // a
    '{8'h39, ROW_CHAR,    7'h20},  // last table entry, space
    '{8'h3B, ROW_SILENT,  7'h00},  // a code past the table
    '{8'hFF, ROW_SILENT,  7'h00},  // all ones, a break
    '{8'h2A, ROW_SILENT,  7'h00},  // left shift down
    '{8'h1E, ROW_CHAR,    7'h41},  // A
    '{8'hE0, ROW_SILENT,  7'h00},
    '{8'hAA, ROW_SILENT,  7'h00},  // prefixed shift release is ignored
    '{8'h02, ROW_CHAR,    7'h21},  // shift still held: !
    '{8'hAA, ROW_SILENT,  7'h00},  // left shift up
    '{8'h3A, ROW_SILENT,  7'h00},  // caps on
    '{8'h10, ROW_CHAR,    7'h51},  // Q
    '{8'h1D, ROW_SILENT,  7'h00},  // ctrl down
    '{8'h2C, ROW_CHAR,    7'h1A},  // ctrl z, caps has no effect
    '{8'h02, ROW_SILENT,  7'h00},  // ctrl with a digit
    '{8'hE0, ROW_SILENT,  7'h00},
    '{8'h9D, ROW_SILENT,  7'h00},  // prefixed ctrl release
    '{8'hE0, ROW_SILENT,  7'h00},
    '{8'hE0, ROW_SILENT,  7'h00},  // repeated prefix stays armed
    '{8'h1C, ROW_CHAR,    7'h0A},  // keypad enter
    '{8'hE0, ROW_SILENT,  7'h00},
    '{8'h35, ROW_CHAR,    7'h2F},  // keypad slash, caps ignored
    '{8'hE0, ROW_SILENT,  7'h00},
    '{8'h10, ROW_SILENT,  7'h00},  // other extended key
    '{8'hE0, ROW_SILENT,  7'h00},
    '{8'h3A, ROW_SILENT,  7'h00},  // prefixed caps turns it off
    '{8'h1A, ROW_PREDICT, 7'h00}
  };

  // character maps indexed by key code
  logic [6:0] plain_map [58] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  logic [6:0] shift_map [58] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  logic       clk;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] scan_byte = 8'h00;
  logic       pop = 1'b0;
  logic       empty;
  logic [6:0] ascii_code;

  // key flags of the local model
  logic ext_armed   = 1'b0;
  logic lshift_held = 1'b0;
  logic rshift_held = 1'b0;
  logic ctrl_held   = 1'b0;
  logic caps_on     = 1'b0;

  logic [6:0] pending_chars [$];

  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned bytes_sent    = 0;
  int unsigned chars_checked = 0;
  int unsigned error_count   = 0;

  ps2_set1_scancode_to_ascii_core dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .scan_byte  (scan_byte),
    .pop        (pop),
    .empty      (empty),
    .ascii_code (ascii_code)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // fixed upper bound on the run
  initial begin
    #2ms;
    $display("timeout with %0d characters outstanding", pending_chars.size());
    $display("ps2_set1_scancode_to_ascii_core: mismatch");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] error: %s", $realtime, msg);
    error_count++;
  endtask

  // advance the key flags by one byte; returns 1 when a character comes out
  function automatic logic translate_byte(input logic [7:0] b, output logic [6:0] ch);
    logic       ext;
    logic       brk;
    logic [6:0] key;
    logic [6:0] c;
    ch = 7'h00;
    if (b == ps2s1_pkg::EXT_PREFIX) begin
      ext_armed = 1'b1;
      return 1'b0;
    end
    ext = ext_armed;
    ext_armed = 1'b0;
    brk = b[ps2s1_pkg::BREAK_BIT];
    key = b[6:0];
    case (key)
      ps2s1_pkg::KEY_LSHIFT: begin
        if (!ext) lshift_held = !brk;
        return 1'b0;
      end
      ps2s1_pkg::KEY_RSHIFT: begin
        if (!ext) rshift_held = !brk;
        return 1'b0;
      end
      ps2s1_pkg::KEY_CTRL: begin
        ctrl_held = !brk;
        return 1'b0;
      end
      ps2s1_pkg::KEY_ALT: return 1'b0;
      ps2s1_pkg::KEY_CAPS: begin
        if (!brk) caps_on = !caps_on;
        return 1'b0;
      end
      default: ;
    endcase
    if (brk) return 1'b0;
    // extended makes: only keypad enter and slash map
    if (ext) begin
      if (key == ps2s1_pkg::KEY_KP_ENTER) ch = ps2s1_pkg::CH_LF;
      else if (key == ps2s1_pkg::KEY_KP_SLASH) ch = ps2s1_pkg::CH_SLASH;
      return ch != 7'h00;
    end
    if (key >= ps2s1_pkg::TABLE_SIZE) return 1'b0;
    c = (lshift_held || rshift_held) ? shift_map[key] : plain_map[key];
    if (c == 7'h00) return 1'b0;
    // ctrl letters map to 1..26, other ctrl combos are dropped
    if (ctrl_held) begin
      if (c >= 7'h61 && c <= 7'h7A) ch = c - 7'h60;
      else if (c >= 7'h41 && c <= 7'h5A) ch = c - 7'h40;
      return ch != 7'h00;
    end
    if (caps_on && ((c >= 7'h61 && c <= 7'h7A) || (c >= 7'h41 && c <= 7'h5A)))
      c = c ^ ps2s1_pkg::CASE_BIT;
    ch = c;
    return 1'b1;
  endfunction

  // push one word, with random idle cycles ahead of it
  task automatic send_word(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    scan_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  // push one word and queue whatever character the model predicts
  task automatic send_predicted(input logic [7:0] b);
    logic [6:0] ch;
    send_word(b);
    if (translate_byte(b, ch)) pending_chars.push_back(ch);
  endtask

  // one burst of typing activity
  task automatic type_key_event();
    int unsigned pick;
    logic [6:0]  key;
    logic        brk;
    pick = $urandom_range(99);
    brk = 1'($urandom_range(1));
    if (pick < 45) begin
      // ordinary key, usually followed by its release
      key = 7'($urandom_range(57));
      send_predicted({1'b0, key});
      if ($urandom_range(9) < 7) send_predicted({1'b1, key});
    end else if (pick < 58) begin
      key = $urandom_range(1) ? ps2s1_pkg::KEY_LSHIFT : ps2s1_pkg::KEY_RSHIFT;
      send_predicted({brk, key});
    end else if (pick < 66) begin
      if ($urandom_range(3) == 0) send_predicted(ps2s1_pkg::EXT_PREFIX);
      send_predicted({brk, ps2s1_pkg::KEY_CTRL});
    end else if (pick < 72) begin
      send_predicted({1'b0, ps2s1_pkg::KEY_CAPS});
      if ($urandom_range(1)) send_predicted({1'b1, ps2s1_pkg::KEY_CAPS});
    end else if (pick < 84) begin
      // prefixed sequence, sometimes with a doubled prefix
      send_predicted(ps2s1_pkg::EXT_PREFIX);
      if ($urandom_range(7) == 0) send_predicted(ps2s1_pkg::EXT_PREFIX);
      case ($urandom_range(7))
        0, 1: key = ps2s1_pkg::KEY_KP_ENTER;
        2:    key = ps2s1_pkg::KEY_KP_SLASH;
        3:    key = $urandom_range(1) ? ps2s1_pkg::KEY_LSHIFT : ps2s1_pkg::KEY_RSHIFT;
        4:    key = ps2s1_pkg::KEY_CTRL;
        5:    key = ps2s1_pkg::KEY_CAPS;
        6:    key = ps2s1_pkg::KEY_ALT;
        default: key = 7'($urandom_range(127));
      endcase
      send_predicted({($urandom_range(9) < 3), key});
    end else if (pick < 90) begin
      send_predicted({brk, ps2s1_pkg::KEY_ALT});
    end else begin
      send_predicted(8'($urandom_range(255)));
    end
  endtask

  // result side: check each popped word, then pick the next pop
  initial begin
    logic [6:0] want;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (pending_chars.size() == 0) begin
          flag_mismatch($sformatf("unexpected character 0x%02h", ascii_code));
        end else begin
          want = pending_chars.pop_front();
          chars_checked++;
          if (ascii_code !== want)
            flag_mismatch($sformatf("ascii_code 0x%02h, expected 0x%02h", ascii_code, want));
        end
      end
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // stimulus
  initial begin
    logic [6:0]  ch;
    logic        has_char;
    int unsigned phase_start;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table, no idling
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_word(directed_rows[i].scan);
      has_char = translate_byte(directed_rows[i].scan, ch);
      case (directed_rows[i].kind)
        ROW_PREDICT: if (has_char) pending_chars.push_back(ch);
        ROW_CHAR:    pending_chars.push_back(directed_rows[i].want);
        default: ;
      endcase
    end

    // random typing over four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 50; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 50; end
        default: begin send_idle_pct = 34; pop_stall_pct = 34; end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < WORDS_PER_PHASE) type_key_event();
    end
    push <= 1'b0;

    // drain, then watch for stray output
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d scancode bytes (%0d directed) through four idling phases",
             bytes_sent, NUM_ROWS);
    $display("checked %0d characters, %0d errors", chars_checked, error_count);
    if (error_count == 0) begin
      $display("ps2_set1_scancode_to_ascii_core: match");
    end else begin
      $display("ps2_set1_scancode_to_ascii_core: mismatch");
    end
    $finish;
  end

endmodule
